>>> src/plk_pkg.sv
// ----------------------------------------------------------------------------
// plk_pkg
// Shared types and codes for the positional list deque.
// ----------------------------------------------------------------------------
`default_nettype none

package plk_pkg;

  // Width of a slot index carried on the shift control; covers DEPTH up to 4096.
  localparam int AT_W = 12;

  // Widths of the word fields.
  localparam int CMD_W   = 4;
  localparam int POS_W   = 6;
  localparam int VAL_W   = 32;
  localparam int CNT_O_W = 7;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_BACK  = 4'd0,
    CMD_PUSH_FRONT = 4'd1,
    CMD_INSERT     = 4'd2,
    CMD_POP_BACK   = 4'd3,
    CMD_POP_FRONT  = 4'd4,
    CMD_ERASE      = 4'd5,
    CMD_FRONT      = 4'd6,
    CMD_BACK       = 4'd7,
    CMD_AT         = 4'd8,
    CMD_REPLACE    = 4'd9,
    CMD_CLEAR      = 4'd10
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  // What the row of slots does this cycle.
  typedef enum logic [1:0] {
    ACT_NONE  = 2'd0,
    ACT_OPEN  = 2'd1,  // slots above 'at' take from the left, slot 'at' loads
    ACT_CLOSE = 2'd2,  // slots at and above 'at' take from the right
    ACT_WRITE = 2'd3   // slot 'at' loads
  } act_t;

  typedef struct packed {
    act_t            act;
    logic [AT_W-1:0] at;
  } shift_op_t;

  typedef struct packed {
    logic    rd_en;
    status_t status;
  } dec_res_t;

endpackage

`default_nettype wire

>>> src/plk_cell.sv
// ----------------------------------------------------------------------------
// plk_cell
// One storage slot of the list; loads, holds or takes a neighbour's word.
// ----------------------------------------------------------------------------
`default_nettype none

module plk_cell
  import plk_pkg::*;
#(
  parameter int IDX = 0
) (
  input  logic                    clk,
  input  shift_op_t               op,
  input  logic signed [VAL_W-1:0] value,
  input  logic signed [VAL_W-1:0] left,
  input  logic signed [VAL_W-1:0] right,
  output logic signed [VAL_W-1:0] q
);

  localparam logic [AT_W-1:0] MY_IDX = AT_W'(IDX);

  always_ff @(posedge clk) begin
    unique case (op.act)
      ACT_OPEN: begin
        if (op.at == MY_IDX) begin
          q <= value;
        end else if (MY_IDX > op.at) begin
          q <= left;
        end
      end
      ACT_CLOSE: begin
        if (MY_IDX >= op.at) begin
          q <= right;
        end
      end
      ACT_WRITE: begin
        if (op.at == MY_IDX) begin
          q <= value;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

>>> src/plk_decode.sv
// ----------------------------------------------------------------------------
// plk_decode
// Command decode: checks, status, row action, read slot and new count.
// ----------------------------------------------------------------------------
`default_nettype none

module plk_decode
  import plk_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  logic [CMD_W-1:0]            cmd,
  input  logic [POS_W-1:0]            pos,
  input  logic [$clog2(DEPTH+1)-1:0]  cnt,
  output shift_op_t                   op,
  output dec_res_t                    res,
  output logic [$clog2(DEPTH)-1:0]    rd_at,
  output logic [$clog2(DEPTH+1)-1:0]  cnt_next
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = $clog2(DEPTH);
  localparam int PW = (CW > POS_W) ? CW : POS_W;

  logic [PW-1:0] pos_w;
  logic [PW-1:0] cnt_w;
  logic [PW-1:0] last_w;
  logic          empty;
  logic          full;
  cmd_t          c;

  assign pos_w  = PW'(pos);
  assign cnt_w  = PW'(cnt);
  assign last_w = cnt_w - PW'(1);
  assign empty  = (cnt_w == '0);
  assign full   = (cnt_w == PW'(DEPTH));
  assign c      = cmd_t'(cmd);

  always_comb begin
    op.act     = ACT_NONE;
    op.at      = '0;
    res.rd_en  = 1'b0;
    res.status = ST_OK;
    rd_at      = '0;
    cnt_next   = cnt;
    unique case (c)
      CMD_PUSH_BACK, CMD_PUSH_FRONT: begin
        if (full) begin
          res.status = ST_FULL;
        end else begin
          op.act   = ACT_OPEN;
          op.at    = (c == CMD_PUSH_BACK) ? AT_W'(cnt_w) : '0;
          cnt_next = CW'(cnt_w + PW'(1));
        end
      end
      CMD_INSERT: begin
        if (pos_w > cnt_w) begin
          res.status = ST_RANGE;
        end else if (full) begin
          res.status = ST_FULL;
        end else begin
          op.act   = ACT_OPEN;
          op.at    = AT_W'(pos_w);
          cnt_next = CW'(cnt_w + PW'(1));
        end
      end
      CMD_POP_BACK, CMD_POP_FRONT, CMD_FRONT, CMD_BACK: begin
        if (empty) begin
          res.status = ST_EMPTY;
        end else begin
          res.rd_en = 1'b1;
          rd_at = (c == CMD_POP_BACK || c == CMD_BACK) ? AW'(last_w) : '0;
          if (c == CMD_POP_BACK || c == CMD_POP_FRONT) begin
            op.act   = ACT_CLOSE;
            op.at    = (c == CMD_POP_BACK) ? AT_W'(last_w) : '0;
            cnt_next = CW'(last_w);
          end
        end
      end
      CMD_ERASE, CMD_AT, CMD_REPLACE: begin
        if (empty) begin
          res.status = ST_EMPTY;
        end else if (pos_w >= cnt_w) begin
          res.status = ST_RANGE;
        end else begin
          op.at = AT_W'(pos_w);
          rd_at = AW'(pos_w);
          if (c == CMD_REPLACE) begin
            op.act = ACT_WRITE;
          end else begin
            res.rd_en = 1'b1;
            if (c == CMD_ERASE) begin
              op.act   = ACT_CLOSE;
              cnt_next = CW'(last_w);
            end
          end
        end
      end
      CMD_CLEAR: begin
        cnt_next = '0;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

>>> src/positional_list_deque.sv
// ----------------------------------------------------------------------------
// positional_list_deque
// Bounded ordered list of signed 32-bit words held in a row of shifting slots.
// ----------------------------------------------------------------------------
//   channel   dir  handshake               payload
//   command   in   cmd_valid / cmd_stall   cmd, pos, value
//   result    out  res_valid / res_stall   data, status, count, is_empty
//
// One command per cycle unless the result side stalls: the row of slots shifts
// every entry at once on an insert, push, pop or erase.
// The result word appears in the output register in the cycle after acceptance.
// A new command is taken while the result register is empty or being drained;
// a stalled result holds and blocks the command side.
// Reset clears the count and the result valid; slot contents are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module positional_list_deque
  import plk_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cmd_valid,
  output logic                      cmd_stall,
  input  logic [CMD_W-1:0]          cmd,
  input  logic [POS_W-1:0]          pos,
  input  logic signed [VAL_W-1:0]   value,
  output logic                      res_valid,
  input  logic                      res_stall,
  output logic signed [VAL_W-1:0]   data,
  output logic [1:0]                status,
  output logic [CNT_O_W-1:0]        count,
  output logic                      is_empty
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = $clog2(DEPTH);

  // Control state
  logic [CW-1:0] cnt;
  logic          accept;

  // Decode outputs
  shift_op_t     dec_op;
  shift_op_t     row_op;
  dec_res_t      dec_res;
  logic [AW-1:0] rd_at;
  logic [CW-1:0] cnt_next;

  // Slot contents
  logic signed [VAL_W-1:0] slot_q [DEPTH];

  // Result register
  status_t st_reg;

  // The result register is the only thing that can hold the command side back.
  assign cmd_stall = res_valid & res_stall;
  assign accept    = cmd_valid & ~cmd_stall;

  plk_decode #(
    .DEPTH (DEPTH)
  ) u_decode (
    .cmd      (cmd),
    .pos      (pos),
    .cnt      (cnt),
    .op       (dec_op),
    .res      (dec_res),
    .rd_at    (rd_at),
    .cnt_next (cnt_next)
  );

  // The row only moves on an accepted command.
  always_comb begin
    row_op = dec_op;
    if (!accept) begin
      row_op.act = ACT_NONE;
    end
  end

  // Row of slots: slot i looks left to i-1 and right to i+1.  Slot 0 takes
  // the command word from the left; the last slot keeps its own word on a
  // close since nothing lies beyond it.
  for (genvar i = 0; i < DEPTH; i++) begin : g_slot
    logic signed [VAL_W-1:0] left;
    logic signed [VAL_W-1:0] right;

    if (i == 0) begin : g_first
      assign left = value;
    end else begin : g_mid_l
      assign left = slot_q[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right = slot_q[i];
    end else begin : g_mid_r
      assign right = slot_q[i+1];
    end

    plk_cell #(
      .IDX (i)
    ) u_slot (
      .clk   (clk),
      .op    (row_op),
      .value (value),
      .left  (left),
      .right (right),
      .q     (slot_q[i])
    );
  end

  // Element count
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (accept) begin
      cnt <= cnt_next;
    end
  end

  // Result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  // Result payload; read word comes from the pre-shift contents.
  always_ff @(posedge clk) begin
    if (accept) begin
      data     <= dec_res.rd_en ? slot_q[rd_at] : '0;
      st_reg   <= dec_res.status;
      count    <= CNT_O_W'(cnt_next);
      is_empty <= (cnt_next == '0);
    end
  end

  assign status = st_reg;

endmodule

`default_nettype wire

>>> src/plk_checker.sv
// ----------------------------------------------------------------------------
// plk_checker
// Port-level checks for the positional list deque, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module plk_checker
  import plk_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input logic                    clk,
  input logic                    rst,
  input logic                    res_valid,
  input logic                    res_stall,
  input logic signed [VAL_W-1:0] data,
  input logic [1:0]              status,
  input logic [CNT_O_W-1:0]      count,
  input logic                    is_empty
);

  // Reset empties the result register.
  a_reset_clears: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

  // A stalled result word holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(data) && $stable(status)
      && $stable(count) && $stable(is_empty))
    else $error("stalled result changed");

  // Empty flag agrees with the count.
  a_empty: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (is_empty == (count == '0)))
    else $error("is_empty disagrees with count");

  // A failed command returns no data.
  a_err_data: assert property (@(posedge clk) disable iff (rst)
    res_valid && status != ST_OK |-> data == '0)
    else $error("data on failed command");

  // Full is only reported at capacity.
  a_full: assert property (@(posedge clk) disable iff (rst)
    res_valid && status == ST_FULL |-> count == CNT_O_W'(DEPTH))
    else $error("full reported below capacity");

endmodule

bind positional_list_deque plk_checker #(
  .DEPTH (DEPTH)
) u_plk_checker (
  .clk       (clk),
  .rst       (rst),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .data      (data),
  .status    (status),
  .count     (count),
  .is_empty  (is_empty)
);

`default_nettype wire
